[rtl/core/fbblit_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// fbblit_pkg: shared types and constants of the frame buffer blit engine
// Command codes, field widths and configuration register decode.
// ---------------------------------------------------------------------------
package fbblit_pkg;

	localparam int REQ_W   = 3;
	localparam int COORD_W = 10;
	localparam int PITCH_W = 11;
	localparam int COLOR_W = 32;
	localparam int GLYPH_W = 64;

	// Glyph rows are always one byte wide
	localparam int GLYPH_COLS = 8;

	// Holds any pixel address the engine can form and any store depth
	localparam int ADDR_W = 25;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic CFG_IDX_ROW_PITCH = 1'b0;
	localparam logic [PITCH_W-1:0] ROW_PITCH_RESET = 11'd256;

	typedef enum logic [REQ_W-1:0] {
		REQ_READ  = 3'd0,
		REQ_WRITE = 3'd1,
		REQ_FILL  = 3'd2,
		REQ_GLYPH = 3'd3,
		REQ_COPY  = 3'd4
	} req_e_t;

endpackage : fbblit_pkg
`default_nettype wire

[rtl/core/framebuffer_fill_blit_engine_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// framebuffer_fill_blit_engine_unit: 2D fill, glyph and copy engine
// Frame memory with a programmable row pitch, driven by one command word at
// a time; each command returns one result word.
// ---------------------------------------------------------------------------
// One command word is taken at a time, and in_stall stays high until its
// result word is in the output register. State S_MUL forms the row base
// y*pitch on the multiplier; a copy also visits S_MULSRC for the source base.
// The sequencer then touches one pixel per cycle through the single memory
// port. A write steps through S_MUL, S_PIX and S_DONE; a read adds S_RDWAIT
// before S_DONE unless the address is beyond the store. A fill or glyph
// visits S_PIX once per pixel, an empty fill or copy goes from S_MUL straight
// to S_DONE, and a copy alternates S_PIX and S_CPYWR, since each pixel is
// read then written. S_DONE holds while a result word stalls in the output
// register. The next command is taken while a result word waits there.
// Pixels beyond FB_WORDS are not written, read as zero and raise addr_fault.
// No clearing pass is run: pixels read before written are undefined.
module framebuffer_fill_blit_engine_unit #(
	parameter int FB_WORDS   = 65536,
	parameter int PIXEL_BITS = 32,
	parameter int GLYPH_ROWS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fbblit_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [fbblit_pkg::PDATA_W-1:0]    pwdata,
	output logic      [fbblit_pkg::PDATA_W-1:0]    prdata,
	output logic                                   pready,
	// command channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [fbblit_pkg::REQ_W-1:0]      req_type,
	input  wire logic [fbblit_pkg::COORD_W-1:0]    x,
	input  wire logic [fbblit_pkg::COORD_W-1:0]    y,
	input  wire logic [fbblit_pkg::COORD_W-1:0]    width,
	input  wire logic [fbblit_pkg::COORD_W-1:0]    height,
	input  wire logic [fbblit_pkg::COORD_W-1:0]    src_x,
	input  wire logic [fbblit_pkg::COORD_W-1:0]    src_y,
	input  wire logic [fbblit_pkg::COLOR_W-1:0]    fg_color,
	input  wire logic [fbblit_pkg::COLOR_W-1:0]    bg_color,
	input  wire logic [fbblit_pkg::GLYPH_W-1:0]    glyph_lo,
	input  wire logic [fbblit_pkg::GLYPH_W-1:0]    glyph_hi,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [fbblit_pkg::COLOR_W-1:0]    read_data,
	output logic                                   addr_fault
);
	import fbblit_pkg::*;

	localparam int MW = $clog2(FB_WORDS);
	localparam int MUL_W = COORD_W + PITCH_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MUL    = 7'b0000010,
		S_MULSRC = 7'b0000100,
		S_PIX    = 7'b0001000,
		S_CPYWR  = 7'b0010000,
		S_RDWAIT = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [PITCH_W-1:0]    pitch_q;
	logic [COORD_W-1:0]    r_q, c_q;
	logic                  out_valid_q;

	req_e_t                req_q;
	logic [COORD_W-1:0]    x_q, y_q, w_q, h_q, sx_q, sy_q;
	logic [COLOR_W-1:0]    fg_q, bg_q;
	logic [2*GLYPH_W-1:0]  glyph_q;
	logic [ADDR_W-1:0]     dst_base_q, src_base_q;
	logic                  src_bad_q;
	logic                  fault_q;
	logic [COLOR_W-1:0]    data_q;
	logic [COLOR_W-1:0]    read_data_q;
	logic                  addr_fault_q;

	logic [PIXEL_BITS-1:0] mem [FB_WORDS];
	logic [PIXEL_BITS-1:0] mem_rdata_q;

	logic                  cfg_wr;
	logic                  ld_item;
	logic                  src_phase;
	logic [ADDR_W-1:0]     base_sel;
	logic [COORD_W-1:0]    col_sel;
	logic [ADDR_W-1:0]     pix_addr;
	logic                  addr_bad;
	logic [MW-1:0]         mem_idx;
	logic                  glyph_bit;
	logic [PIXEL_BITS-1:0] wr_value;
	logic                  mem_we, mem_re;
	logic                  set_fault;
	logic                  adv;
	logic [COORD_W-1:0]    wlim, hlim;
	logic [COORD_W-1:0]    c_nxt, r_nxt;
	logic                  last_col, last_row;
	logic                  rect_empty;
	logic [MUL_W-1:0]      mul_prod;
	logic                  out_load;

	// ---------------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1] == CFG_IDX_ROW_PITCH);
	assign prdata = (paddr[PADDR_W-1] == CFG_IDX_ROW_PITCH) ? PDATA_W'(pitch_q) : '0;

	// ---------------------------------------------------------------------
	// datapath: one address adder, one multiplier, one memory port
	// ---------------------------------------------------------------------
	always_comb begin
		ld_item   = in_valid && (state_q == S_IDLE);
		// the copy read uses the source corner, every other access the destination
		src_phase = (state_q == S_PIX) && (req_q == REQ_COPY);
		base_sel  = src_phase ? src_base_q : dst_base_q;
		col_sel   = src_phase ? sx_q : x_q;
		pix_addr  = base_sel + ADDR_W'(col_sel) + ADDR_W'(c_q);
		addr_bad  = pix_addr >= ADDR_W'(FB_WORDS);
		mem_idx   = pix_addr[MW-1:0];

		// column c takes bit 7-c of its row byte
		glyph_bit = glyph_q[{r_q[3:0], 3'(GLYPH_COLS - 1) - c_q[2:0]}];

		case (req_q)
			REQ_WRITE, REQ_FILL: wr_value = fg_q[PIXEL_BITS-1:0];
			REQ_GLYPH: wr_value = glyph_bit ? fg_q[PIXEL_BITS-1:0] : bg_q[PIXEL_BITS-1:0];
			REQ_COPY:  wr_value = src_bad_q ? '0 : mem_rdata_q;
			default:   wr_value = '0;
		endcase

		mem_we = !addr_bad && (((state_q == S_PIX)
			&& (req_q inside {REQ_WRITE, REQ_FILL, REQ_GLYPH})) || (state_q == S_CPYWR));
		mem_re = !addr_bad && (state_q == S_PIX) && (req_q inside {REQ_READ, REQ_COPY});
		set_fault = addr_bad && (((state_q == S_PIX)
			&& (req_q inside {REQ_READ, REQ_WRITE, REQ_FILL, REQ_GLYPH, REQ_COPY}))
			|| (state_q == S_CPYWR));
		adv = ((state_q == S_PIX) && (req_q inside {REQ_FILL, REQ_GLYPH}))
			|| (state_q == S_CPYWR);

		wlim     = (req_q == REQ_GLYPH) ? COORD_W'(GLYPH_COLS) : w_q;
		hlim     = (req_q == REQ_GLYPH) ? COORD_W'(GLYPH_ROWS) : h_q;
		c_nxt    = c_q + 1'b1;
		r_nxt    = r_q + 1'b1;
		last_col = (c_nxt == wlim);
		last_row = (r_nxt == hlim);
		rect_empty = (w_q == '0) || (h_q == '0);

		mul_prod = ((state_q == S_MULSRC) ? MUL_W'(sy_q) : MUL_W'(y_q)) * MUL_W'(pitch_q);

		out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_idx] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rdata_q <= mem[mem_idx];
		end
	end

	// ---------------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ld_item) begin
			req_q   <= req_e_t'(req_type);
			x_q     <= x;
			y_q     <= y;
			w_q     <= width;
			h_q     <= height;
			sx_q    <= src_x;
			sy_q    <= src_y;
			fg_q    <= fg_color;
			bg_q    <= bg_color;
			glyph_q <= {glyph_hi, glyph_lo};
			fault_q <= 1'b0;
			data_q  <= '0;
		end
		if (state_q == S_MUL) begin
			dst_base_q <= ADDR_W'(mul_prod);
		end
		if (state_q == S_MULSRC) begin
			src_base_q <= ADDR_W'(mul_prod);
		end
		// step both row bases down one row
		if (adv && last_col && !last_row) begin
			dst_base_q <= dst_base_q + ADDR_W'(pitch_q);
			src_base_q <= src_base_q + ADDR_W'(pitch_q);
		end
		if (src_phase) begin
			src_bad_q <= addr_bad;
		end
		if (set_fault) begin
			fault_q <= 1'b1;
		end
		if (state_q == S_RDWAIT) begin
			data_q <= COLOR_W'(mem_rdata_q);
		end
		if (out_load) begin
			read_data_q  <= data_q;
			addr_fault_q <= fault_q;
		end
	end

	// ---------------------------------------------------------------------
	// sequencer and control
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pitch_q     <= ROW_PITCH_RESET;
			r_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				pitch_q <= pwdata[PITCH_W-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						r_q     <= '0;
						c_q     <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					case (req_q)
						REQ_READ, REQ_WRITE, REQ_GLYPH: state_q <= S_PIX;
						REQ_FILL: state_q <= rect_empty ? S_DONE : S_PIX;
						REQ_COPY: state_q <= rect_empty ? S_DONE : S_MULSRC;
						default:  state_q <= S_DONE;
					endcase
				end
				S_MULSRC: begin
					state_q <= S_PIX;
				end
				S_PIX: begin
					case (req_q)
						REQ_READ:  state_q <= addr_bad ? S_DONE : S_RDWAIT;
						REQ_COPY:  state_q <= S_CPYWR;
						// drop out after the last pixel
						REQ_FILL, REQ_GLYPH: state_q <= (last_col && last_row) ? S_DONE : S_PIX;
						default:   state_q <= S_DONE;
					endcase
				end
				S_CPYWR: begin
					state_q <= (last_col && last_row) ? S_DONE : S_PIX;
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// advance column, then row
			if (adv) begin
				if (last_col) begin
					c_q <= '0;
					if (!last_row) begin
						r_q <= r_nxt;
					end
				end else begin
					c_q <= c_nxt;
				end
			end
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign addr_fault = addr_fault_q;

endmodule : framebuffer_fill_blit_engine_unit
`default_nettype wire

[tb/fbblit_draw_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fbblit_draw_checker: result checker for the frame buffer blit engine
// Keeps a shadow copy of the frame memory and of the row pitch. Each
// accepted command word is applied to the shadow, and its result is queued
// for comparison with the next result word taken from the engine.
// ---------------------------------------------------------------------------
module fbblit_draw_checker #(
	parameter int FB_WORDS   = 65536,
	parameter int PIXEL_BITS = 32,
	parameter int GLYPH_ROWS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fbblit_pkg::PADDR_W-1:0]  paddr,
	input  logic [fbblit_pkg::PDATA_W-1:0]  pwdata,
	input  logic [fbblit_pkg::PDATA_W-1:0]  prdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [fbblit_pkg::REQ_W-1:0]    req_type,
	input  logic [fbblit_pkg::COORD_W-1:0]  x,
	input  logic [fbblit_pkg::COORD_W-1:0]  y,
	input  logic [fbblit_pkg::COORD_W-1:0]  width,
	input  logic [fbblit_pkg::COORD_W-1:0]  height,
	input  logic [fbblit_pkg::COORD_W-1:0]  src_x,
	input  logic [fbblit_pkg::COORD_W-1:0]  src_y,
	input  logic [fbblit_pkg::COLOR_W-1:0]  fg_color,
	input  logic [fbblit_pkg::COLOR_W-1:0]  bg_color,
	input  logic [fbblit_pkg::GLYPH_W-1:0]  glyph_lo,
	input  logic [fbblit_pkg::GLYPH_W-1:0]  glyph_hi,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [fbblit_pkg::COLOR_W-1:0]  read_data,
	input  logic                            addr_fault,
	output int                              mismatch_count,
	output int                              owed_count
);
	import fbblit_pkg::*;

	typedef struct packed {
		logic [COLOR_W-1:0] data;
		logic               fault;
	} pixel_answer_t;

	localparam logic [COLOR_W-1:0] PIX_MASK = COLOR_W'((64'd1 << PIXEL_BITS) - 64'd1);
	localparam int FB_AW = $clog2(FB_WORDS);

	bit [COLOR_W-1:0] shadow_frame [FB_WORDS];
	logic [PITCH_W-1:0] pitch_reg;
	pixel_answer_t      owed_answers[$];
	pixel_answer_t      owed;
	bit                 strayed;
	int                 mismatches = 0;
	int                 owed_total = 0;

	assign mismatch_count = mismatches;
	assign owed_count     = owed_total;

	function automatic longint pixel_addr(longint px, longint py);
		return px + py * longint'(pitch_reg);
	endfunction

	function automatic logic [COLOR_W-1:0] fetch_pixel(longint a);
		if (a >= FB_WORDS) begin
			strayed = 1'b1;
			return '0;
		end
		return shadow_frame[FB_AW'(a)];
	endfunction

	function automatic void store_pixel(longint a, logic [COLOR_W-1:0] v);
		if (a >= FB_WORDS)
			strayed = 1'b1;
		else
			shadow_frame[FB_AW'(a)] = v & PIX_MASK;
	endfunction

	function automatic pixel_answer_t apply_command(
		logic [REQ_W-1:0] op, longint px, longint py, longint w, longint h,
		longint sx, longint sy, logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg,
		logic [GLYPH_W-1:0] glo, logic [GLYPH_W-1:0] ghi);
		pixel_answer_t      ans;
		logic [GLYPH_W-1:0] half;
		logic [7:0]         bits;
		logic [COLOR_W-1:0] moved;
		ans.data = '0;
		strayed = 1'b0;
		case (op)
			REQ_READ:  ans.data = fetch_pixel(pixel_addr(px, py));
			REQ_WRITE: store_pixel(pixel_addr(px, py), fg);
			REQ_FILL: begin
				for (longint r = 0; r < h; r++)
					for (longint c = 0; c < w; c++)
						store_pixel(pixel_addr(px + c, py + r), fg);
			end
			REQ_GLYPH: begin
				for (int r = 0; r < GLYPH_ROWS; r++) begin
					half = (r < 8) ? glo : ghi;
					bits = half[(r % 8) * 8 +: 8];
					// leftmost pixel takes the msb of the row byte
					for (int c = 0; c < GLYPH_COLS; c++)
						store_pixel(pixel_addr(px + c, py + r),
							bits[GLYPH_COLS - 1 - c] ? fg : bg);
				end
			end
			REQ_COPY: begin
				// forward order, so an overlapping copy sees pixels already moved
				for (longint r = 0; r < h; r++)
					for (longint c = 0; c < w; c++) begin
						moved = fetch_pixel(pixel_addr(sx + c, sy + r));
						store_pixel(pixel_addr(px + c, py + r), moved);
					end
			end
			default: ;
		endcase
		ans.fault = strayed;
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_reg = ROW_PITCH_RESET;
			owed_answers.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_answers.size() == 0) begin
					mismatches++;
					$display("%t: result word with nothing owed: read_data %h addr_fault %b",
						$time, read_data, addr_fault);
				end else begin
					owed = owed_answers.pop_front();
					if (read_data !== owed.data) begin
						mismatches++;
						$display("%t: read_data expected %h got %h",
							$time, owed.data, read_data);
					end
					if (addr_fault !== owed.fault) begin
						mismatches++;
						$display("%t: addr_fault expected %b got %b",
							$time, owed.fault, addr_fault);
					end
				end
			end
			if (in_valid && !in_stall)
				owed_answers.push_back(apply_command(req_type, x, y, width, height,
					src_x, src_y, fg_color, bg_color, glyph_lo, glyph_hi));
			if (psel && penable && pready && paddr[PADDR_W-1:2] == CFG_IDX_ROW_PITCH) begin
				if (pwrite) begin
					pitch_reg = pwdata[PITCH_W-1:0];
				end else if (prdata !== PDATA_W'(pitch_reg)) begin
					mismatches++;
					$display("%t: row_pitch readback expected %h got %h",
						$time, PDATA_W'(pitch_reg), prdata);
				end
			end
		end
		owed_total = owed_answers.size();
	end

endmodule : fbblit_draw_checker

[tb/tb_framebuffer_fill_blit_engine_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_framebuffer_fill_blit_engine_unit: regression for the blit engine
// Covers the whole frame with one fill, then runs directed commands at the
// reset pitch and random command streams over a range of row pitches, with
// random gaps on the command side and random stalls on the result side.
// ---------------------------------------------------------------------------
module tb_framebuffer_fill_blit_engine_unit;
	import fbblit_pkg::*;

	localparam int FB_WORDS     = 65536;
	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int PHASE_ITEMS  = 234;
	localparam int COORD_MAX    = (1 << COORD_W) - 1;
	localparam int PITCH_MAX    = (1 << PITCH_W) - 1;
	localparam logic [REQ_W-1:0]   REQ_IDLE_FIRST = 3'd5;
	localparam logic [REQ_W-1:0]   REQ_IDLE_LAST  = 3'd7;
	localparam logic [PADDR_W-1:0] ROW_PITCH_ADDR = PADDR_W'({CFG_IDX_ROW_PITCH, 2'b00});

	typedef struct {
		logic [REQ_W-1:0]   op;
		logic [COORD_W-1:0] x, y, w, h, sx, sy;
		logic [COLOR_W-1:0] fg, bg;
		logic [GLYPH_W-1:0] glo, ghi;
	} blit_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [REQ_W-1:0]   req_type;
	logic [COORD_W-1:0] x, y, width, height, src_x, src_y;
	logic [COLOR_W-1:0] fg_color, bg_color, read_data;
	logic [GLYPH_W-1:0] glyph_lo, glyph_hi;
	logic               addr_fault;
	int                 mismatch_count, owed_count;
	int                 cycle_count = 0;
	int unsigned        cur_pitch;
	int unsigned        stall_len;
	bit                 quiet;

	framebuffer_fill_blit_engine_unit #(.FB_WORDS(FB_WORDS)) dut (.*);

	fbblit_draw_checker #(.FB_WORDS(FB_WORDS)) watch (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: stall for a random count before each word
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			stall_len = quiet ? 0 : $urandom_range(0, 3);
			if (stall_len != 0) begin
				out_stall = 1'b1;
				repeat (stall_len) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// mostly coordinates that land inside the frame at the current pitch
	function automatic logic [COORD_W-1:0] pick_coord(bit is_row);
		int unsigned lim;
		if ($urandom_range(0, 99) < 35)
			return COORD_W'($urandom);
		if (is_row)
			lim = (cur_pitch == 0) ? COORD_MAX : FB_WORDS / cur_pitch - 1;
		else
			lim = (cur_pitch == 0 || cur_pitch > COORD_MAX) ? COORD_MAX : cur_pitch - 1;
		if (lim > COORD_MAX)
			lim = COORD_MAX;
		return COORD_W'($urandom_range(0, lim));
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic blit_cmd_t random_cmd();
		blit_cmd_t   c;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 18)
			c.op = REQ_READ;
		else if (roll < 36)
			c.op = REQ_WRITE;
		else if (roll < 54)
			c.op = REQ_FILL;
		else if (roll < 70)
			c.op = REQ_GLYPH;
		else if (roll < 94)
			c.op = REQ_COPY;
		else
			c.op = REQ_W'($urandom_range(REQ_IDLE_FIRST, REQ_IDLE_LAST));
		c.x   = pick_coord(1'b0);
		c.y   = pick_coord(1'b1);
		c.sx  = pick_coord(1'b0);
		c.sy  = pick_coord(1'b1);
		c.fg  = pick_color();
		c.bg  = pick_color();
		c.glo = {$urandom, $urandom};
		c.ghi = {$urandom, $urandom};
		// keep rectangles small, with the odd long strip
		roll = $urandom_range(0, 99);
		if (roll < 85) begin
			c.w = COORD_W'($urandom_range(0, 12));
			c.h = COORD_W'($urandom_range(0, 12));
		end else if (roll < 97) begin
			c.w = COORD_W'($urandom_range(0, 64));
			c.h = COORD_W'($urandom_range(0, 4));
			if ($urandom_range(0, 1))
				{c.w, c.h} = {c.h, c.w};
		end else if ($urandom_range(0, 1)) begin
			c.w = COORD_W'(COORD_MAX);
			c.h = COORD_W'($urandom_range(0, 1));
		end else begin
			c.w = COORD_W'($urandom_range(0, 1));
			c.h = COORD_W'(COORD_MAX);
		end
		return c;
	endfunction

	function automatic blit_cmd_t shape(logic [REQ_W-1:0] op, int px, int py, int w, int h,
		int sx, int sy, logic [COLOR_W-1:0] fg);
		blit_cmd_t c;
		c    = random_cmd();
		c.op = op;
		c.x  = COORD_W'(px);
		c.y  = COORD_W'(py);
		c.w  = COORD_W'(w);
		c.h  = COORD_W'(h);
		c.sx = COORD_W'(sx);
		c.sy = COORD_W'(sy);
		c.fg = fg;
		return c;
	endfunction

	task automatic issue_command(blit_cmd_t c);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = c.op;
		x        = c.x;
		y        = c.y;
		width    = c.w;
		height   = c.h;
		src_x    = c.sx;
		src_y    = c.sy;
		fg_color = c.fg;
		bg_color = c.bg;
		glyph_lo = c.glo;
		glyph_hi = c.ghi;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (owed_count != 0)
			@(negedge clk);
	endtask

	task automatic cfg_access(bit write_it, logic [PDATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = write_it;
		paddr   = ROW_PITCH_ADDR;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic run_phase(int unsigned pitch, bit calm);
		drain();
		cfg_access(1'b1, pitch);
		cfg_access(1'b0, '0);
		cur_pitch = pitch;
		quiet     = calm;
		repeat (PHASE_ITEMS)
			issue_command(random_cmd());
	endtask

	initial begin
		blit_cmd_t g;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		req_type  = REQ_READ;
		{x, y, width, height, src_x, src_y} = '0;
		{fg_color, bg_color, glyph_lo, glyph_hi} = '0;
		cur_pitch = 32'(ROW_PITCH_RESET);
		quiet     = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		cfg_access(1'b0, '0);

		// cover every pixel once so that later reads never hit unwritten memory
		issue_command(shape(REQ_FILL, 0, 0, 256, 256, 0, 0, 32'hA5A5_5A5A));
		issue_command(shape(REQ_READ, 0, 0, 0, 0, 0, 0, '0));
		issue_command(shape(REQ_READ, 255, 255, 0, 0, 0, 0, '0));
		issue_command(shape(REQ_WRITE, COORD_MAX, COORD_MAX, 0, 0, 0, 0, '1));
		issue_command(shape(REQ_READ, COORD_MAX, COORD_MAX, 0, 0, 0, 0, '0));
		issue_command(shape(REQ_WRITE, 0, 0, 0, 0, 0, 0, '0));
		issue_command(shape(REQ_WRITE, 255, 255, 0, 0, 0, 0, '1));
		issue_command(shape(REQ_READ, 255, 255, 0, 0, 0, 0, '0));
		issue_command(shape(REQ_FILL, 3, 3, 0, 5, 0, 0, 32'h0BAD_F00D));
		issue_command(shape(REQ_FILL, 3, 3, 5, 0, 0, 0, 32'h0BAD_F00D));
		// straddles the end of the frame
		issue_command(shape(REQ_FILL, 250, 254, 10, 3, 0, 0, 32'h1234_5678));
		g     = shape(REQ_GLYPH, 10, 20, 0, 0, 0, 0, 32'h00FF_00FF);
		g.bg  = 32'hFF00_FF00;
		g.glo = 64'h0123_4567_89AB_CDEF;
		g.ghi = 64'hFEDC_BA98_7654_3210;
		issue_command(g);
		issue_command(shape(REQ_GLYPH, 250, 250, 0, 0, 0, 0, 32'h5555_AAAA));
		// leftmost column takes the msb, fourth column a clear bit
		issue_command(shape(REQ_READ, 10, 20, 0, 0, 0, 0, '0));
		issue_command(shape(REQ_READ, 13, 20, 0, 0, 0, 0, '0));
		issue_command(shape(REQ_COPY, 100, 100, 8, 16, 10, 20, '0));
		issue_command(shape(REQ_COPY, 1, 0, 20, 2, 0, 0, '0));
		issue_command(shape(REQ_COPY, 40, 40, 0, 7, 0, 0, '0));
		issue_command(shape(REQ_COPY, 40, 40, 2, 2, COORD_MAX, COORD_MAX, '0));
		issue_command(shape(REQ_FILL, 0, 0, COORD_MAX, 1, 0, 0, 32'h8000_0001));
		issue_command(shape(REQ_FILL, 0, 0, 1, COORD_MAX, 0, 0, 32'h7FFF_FFFE));
		issue_command(shape(REQ_COPY, 0, 1, COORD_MAX, 1, 0, 0, '0));
		issue_command(shape(REQ_READ, COORD_MAX, 0, 0, 0, 0, 0, '0));
		for (int k = REQ_IDLE_FIRST; k <= REQ_IDLE_LAST; k++)
			issue_command(shape(REQ_W'(k), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom));

		run_phase(1, 1'b0);
		run_phase(COORD_MAX + 1, 1'b0);
		run_phase(0, 1'b0);
		run_phase(PITCH_MAX, 1'b1);
		run_phase(32'(ROW_PITCH_RESET), 1'b0);
		run_phase($urandom_range(2, COORD_MAX), 1'b0);
		run_phase($urandom_range(1, COORD_MAX + 1), 1'b1);
		run_phase($urandom_range(2, COORD_MAX), 1'b0);

		drain();
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule : tb_framebuffer_fill_blit_engine_unit
